/* rtl/rbot_pkg.sv */
// Package with the types, codes and sizes shared by the ring buffer overrun tracker.
package rbot_pkg;

    // Number of slots in the ring and the width of a slot index.
    localparam int DEPTH = 1024;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Widths of one sample word and of a stored slot.
    localparam int WORD_W = 32;
    localparam int SLOT_W = 2 * WORD_W;
    localparam int MARK_W = 2;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_APPEND  = 2'd0;
    localparam logic [1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [1:0] FUNC_STATUS  = 2'd2;

    // Last access recorded for each slot.
    typedef enum logic [MARK_W-1:0] {
        MARK_UNVISITED = 2'd0,
        MARK_WRITTEN   = 2'd1,
        MARK_READ      = 2'd2
    } mark_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } state_t;

    // One request beat.
    typedef struct packed {
        logic [1:0]        func;
        logic [WORD_W-1:0] data_re;
        logic [WORD_W-1:0] data_im;
    } req_t;

    // One response beat.
    typedef struct packed {
        logic [WORD_W-1:0] read_re;
        logic [WORD_W-1:0] read_im;
        logic              overrun_seen;
        logic              underrun_seen;
    } rsp_t;

    // Next ring position, wrapping from the last slot to slot zero.
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos);
        logic [PTR_W-1:0] nxt;
        if (pos == PTR_W'(DEPTH - 1))
            nxt = '0;
        else
            nxt = pos + 1'b1;
        return nxt;
    endfunction

endpackage

/* rtl/rbot_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module rbot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ring_buffer_overrun_tracker.sv */
// Top level of the ring buffer overrun tracker: controller, slot memory and mark memory.
//
//  Channel | Handshake               | Beat    | Contents
//  --------+-------------------------+---------+------------------------------------
//  request | req_valid / req_stall   | req     | func, data_re, data_im
//  response| rsp_valid / rsp_stall   | rsp     | read_re, read_im, overrun/underrun
//
// In the idle state a request reads the slot's mark and sample from the memories; in
// the access state it updates the flags, writes slot and mark (append) or mark (extract)
// and loads the response. After reset, while req_stall is high, every slot is zeroed.
// A waiting response does not block the next request; a new response waits in
// the access state only while the previous one is still stalled.
module ring_buffer_overrun_tracker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rbot_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rbot_pkg::rsp_t rsp
);

    import rbot_pkg::*;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [PTR_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [PTR_W-1:0]  rd_pos_reg, rd_pos_next;
    logic              ov_reg, ov_next;
    logic              un_reg, un_next;
    logic [1:0]        func_reg, func_next;
    logic [SLOT_W-1:0] din_reg, din_next;
    logic [PTR_W-1:0]  addr_reg, addr_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              mem_rd_en;
    logic [PTR_W-1:0]  mem_rd_addr;
    logic              slot_wr_en;
    logic              mark_wr_en;
    logic [PTR_W-1:0]  mem_wr_addr;
    logic [SLOT_W-1:0] slot_wr_data;
    logic [MARK_W-1:0] mark_wr_data;
    logic [SLOT_W-1:0] slot_rd_data;
    logic [MARK_W-1:0] mark_rd_data;
    logic              req_fire;
    logic              rsp_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sample memory: real part in the upper word, imaginary in the lower.
    rbot_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (slot_rd_data)
    );

    // Mark memory: last access per slot.
    rbot_ram #(
        .WIDTH (MARK_W),
        .DEPTH (DEPTH)
    ) u_mark_ram (
        .clk     (clk),
        .wr_en   (mark_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mark_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mark_rd_data)
    );

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wr_pos_reg    <= '0;
            rd_pos_reg    <= '0;
            ov_reg        <= 1'b0;
            un_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wr_pos_reg    <= wr_pos_next;
            rd_pos_reg    <= rd_pos_next;
            ov_reg        <= ov_next;
            un_reg        <= un_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        din_reg  <= din_next;
        addr_reg <= addr_next;
        rsp_reg  <= rsp_next;
    end

    // Next state, memory accesses and response.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        wr_pos_next    = wr_pos_reg;
        rd_pos_next    = rd_pos_reg;
        ov_next        = ov_reg;
        un_next        = un_reg;
        func_next      = func_reg;
        din_next       = din_reg;
        addr_next      = addr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        mem_rd_en    = 1'b0;
        mem_rd_addr  = addr_reg;
        slot_wr_en   = 1'b0;
        mark_wr_en   = 1'b0;
        mem_wr_addr  = addr_reg;
        slot_wr_data = din_reg;
        mark_wr_data = MARK_UNVISITED;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one slot and its mark per cycle.
                slot_wr_en   = 1'b1;
                mark_wr_en   = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                slot_wr_data = '0;
                mark_wr_data = MARK_UNVISITED;
                if (clr_cnt_reg == PTR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end

            ST_IDLE:
            begin
                // Advance the write position (append) or read position (extract) and read the next slot.
                if (req_fire)
                begin
                    func_next = req.func;
                    din_next  = {req.data_re, req.data_im};
                    if (req.func == FUNC_APPEND)
                    begin
                        wr_pos_next = advance(wr_pos_reg);
                        addr_next   = advance(wr_pos_reg);
                    end
                    else
                    begin
                        rd_pos_next = advance(rd_pos_reg);
                        addr_next   = advance(rd_pos_reg);
                    end
                    if (req.func == FUNC_EXTRACT)
                        rd_pos_next = advance(rd_pos_reg);
                    else
                        rd_pos_next = rd_pos_reg;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = addr_next;
                    state_next  = ST_ACCESS;
                end
            end

            ST_ACCESS:
            begin
                // Update flags, write slot and mark (append) or mark (extract), load the response.
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.read_re       = '0;
                    rsp_next.read_im       = '0;
                    rsp_next.overrun_seen  = ov_reg;
                    rsp_next.underrun_seen = un_reg;
                    case (func_reg)
                        FUNC_APPEND:
                        begin
                            slot_wr_en   = 1'b1;
                            mark_wr_en   = 1'b1;
                            mark_wr_data = MARK_WRITTEN;
                            if (mark_rd_data == MARK_WRITTEN)
                            begin
                                ov_next               = 1'b1;
                                rsp_next.overrun_seen = 1'b1;
                            end
                        end
                        FUNC_EXTRACT:
                        begin
                            mark_wr_en       = 1'b1;
                            mark_wr_data     = MARK_READ;
                            rsp_next.read_re = slot_rd_data[SLOT_W-1:WORD_W];
                            rsp_next.read_im = slot_rd_data[WORD_W-1:0];
                            if (mark_rd_data == MARK_READ)
                            begin
                                un_next                = 1'b1;
                                rsp_next.underrun_seen = 1'b1;
                            end
                        end
                        FUNC_STATUS:
                        begin
                            ov_next = 1'b0;
                            un_next = 1'b0;
                        end
                        default:
                        begin
                            ov_next = ov_reg;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
